// File: rtl/core/jitf_pkg.sv
// Package: widths, register map, configuration and divider types, sequencer states.
package jitf_pkg;

  localparam int unsigned Joints     = 7;
  localparam int unsigned JointW     = 3;
  localparam int unsigned WindowMax  = 64;
  localparam int unsigned PtrW       = $clog2(WindowMax);
  localparam int unsigned CntW       = PtrW + 1;
  localparam int unsigned RingDepth  = Joints * WindowMax;
  localparam int unsigned RingAw     = JointW + PtrW;

  localparam int unsigned PosW       = 18;
  localparam int unsigned ErrW       = PosW + 1;
  localparam int unsigned TorqueW    = 24;
  localparam int unsigned GainW      = 24;
  localparam int unsigned LimW       = 23;
  localparam int unsigned WinW       = 7;
  localparam int unsigned FracShift  = 14;
  localparam int unsigned ProdW      = GainW + 1 + ErrW;
  localparam int unsigned AccW       = ProdW + 1;
  localparam int unsigned SumW       = TorqueW + PtrW;
  localparam int unsigned StepW      = TorqueW + 3;
  localparam int unsigned DivCntW    = $clog2(SumW);

  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned ApbAddrW   = RegIdxW + 2;

  localparam logic [GainW-1:0]   StiffnessRst = GainW'(512000);
  localparam logic [GainW-1:0]   DampingRst   = GainW'(23040);
  localparam logic [LimW-1:0]    LimitRst     = LimW'(51200);
  localparam logic [WinW-1:0]    WindowRst    = WinW'(50);
  localparam logic [LimW-1:0]    MaxStepRst   = LimW'(256);

  typedef enum logic [RegIdxW-1:0] {
    RegStiffness,
    RegDamping,
    RegTorqueLimit,
    RegAverageWindow,
    RegMaxStep
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulK,
    StMulD,
    StClip,
    StUpdate,
    StDiv,
    StSlew
  } ctrl_state_e;

  typedef struct packed {
    logic [GainW-1:0] stiffness;
    logic [GainW-1:0] damping;
    logic [LimW-1:0]  torque_limit;
    logic [WinW-1:0]  average_window;
    logic [LimW-1:0]  max_step;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/jitf_in_if.sv
// Interface: sample input channel.
interface jitf_in_if import jitf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [JointW-1:0]         joint;
  logic signed [PosW-1:0]    position;
  logic signed [PosW-1:0]    velocity;
  logic signed [PosW-1:0]    desired_position;
  logic signed [TorqueW-1:0] feedforward_torque;

  modport source (
    output valid, joint, position, velocity, desired_position, feedforward_torque,
    input  ready
  );
  modport sink (
    input  valid, joint, position, velocity, desired_position, feedforward_torque,
    output ready
  );
endinterface

// File: rtl/core/jitf_out_if.sv
// Interface: torque command output channel.
interface jitf_out_if import jitf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [JointW-1:0]         out_joint;
  logic signed [TorqueW-1:0] torque_command;

  modport source (
    output valid, out_joint, torque_command,
    input  ready
  );
  modport sink (
    input  valid, out_joint, torque_command,
    output ready
  );
endinterface

// File: rtl/core/jitf_regs.sv
// APB configuration registers.
module jitf_regs import jitf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness      <= StiffnessRst;
      cfg_q.damping        <= DampingRst;
      cfg_q.torque_limit   <= LimitRst;
      cfg_q.average_window <= WindowRst;
      cfg_q.max_step       <= MaxStepRst;
    end else if (wr_en) begin
      case (idx)
        RegStiffness:     cfg_q.stiffness      <= pwdata[GainW-1:0];
        RegDamping:       cfg_q.damping        <= pwdata[GainW-1:0];
        RegTorqueLimit:   cfg_q.torque_limit   <= pwdata[LimW-1:0];
        RegAverageWindow: cfg_q.average_window <= pwdata[WinW-1:0];
        RegMaxStep:       cfg_q.max_step       <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegStiffness:     prdata = ApbDataW'(cfg_q.stiffness);
      RegDamping:       prdata = ApbDataW'(cfg_q.damping);
      RegTorqueLimit:   prdata = ApbDataW'(cfg_q.torque_limit);
      RegAverageWindow: prdata = ApbDataW'(cfg_q.average_window);
      RegMaxStep:       prdata = ApbDataW'(cfg_q.max_step);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/jitf_div.sv
// Restoring serial divider, one quotient bit per cycle.
module jitf_div import jitf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    dvs_q;
  logic [SumW-1:0]    quo_q;
  logic [CntW:0]      trial;
  logic               fit;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign fit   = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(SumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fit ? CntW'(trial - {1'b0, dvs_q}) : trial[CntW-1:0];
      quo_q <= {quo_q[SumW-2:0], fit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: rtl/core/jitf_ctrl.sv
// Sequencer with shared multiplier, sample ring, per-joint state and output register.
module jitf_ctrl import jitf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  jitf_in_if.sink    in_i,
  jitf_out_if.source out_o,
  output div_req_t   div_req_o,
  input  div_rsp_t   div_rsp_i
);

  ctrl_state_e state_q, state_d;

  logic [JointW-1:0]         joint_q;
  logic signed [ErrW-1:0]    err_q;
  logic signed [PosW-1:0]    vel_q;
  logic signed [TorqueW-1:0] ff_q;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [TorqueW-1:0] tau_q, tau_d;
  logic                      neg_q;

  logic [CntW-1:0]           cnt_q  [Joints];
  logic [PtrW-1:0]           head_q [Joints];
  logic signed [SumW-1:0]    sum_q  [Joints];
  logic signed [TorqueW-1:0] last_q [Joints];
  logic [Joints-1:0]         has_q;

  logic signed [TorqueW-1:0] ring_mem [RingDepth];
  logic signed [TorqueW-1:0] ring_rd_q;
  logic [RingAw-1:0]         ring_ra;
  logic [RingAw-1:0]         ring_wa;

  logic                      out_valid_q;
  logic [JointW-1:0]         out_joint_q;
  logic signed [TorqueW-1:0] out_torque_q;

  logic                      accept;
  logic                      out_free;
  logic                      load_out;
  logic                      ring_re;
  logic                      ring_we;

  logic signed [GainW:0]     mul_a;
  logic signed [ErrW-1:0]    mul_b;
  logic signed [ProdW-1:0]   prod;

  logic signed [AccW-1:0]    shr;
  logic signed [AccW-1:0]    lim;

  logic [WinW-1:0]           win;
  logic                      drop;
  logic [CntW-1:0]           cnt_new;
  logic signed [SumW-1:0]    sum_new;

  logic [TorqueW-1:0]        q24;
  logic signed [StepW-1:0]   mag;
  logic signed [StepW-1:0]   avg;
  logic signed [StepW-1:0]   prev;
  logic signed [StepW-1:0]   stp;
  logic signed [StepW-1:0]   dlt;
  logic signed [StepW-1:0]   res;
  logic signed [TorqueW-1:0] res_c;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == StSlew) && out_free;
  assign ring_re    = (state_q == StMulK);
  assign ring_we    = (state_q == StUpdate);

  assign out_o.valid          = out_valid_q;
  assign out_o.out_joint      = out_joint_q;
  assign out_o.torque_command = out_torque_q;

  // shared multiplier
  always_comb begin
    mul_a = (state_q == StMulK) ? signed'({1'b0, cfg_i.stiffness})
                                : signed'({1'b0, cfg_i.damping});
    mul_b = (state_q == StMulK) ? err_q : ErrW'(vel_q);
    prod  = mul_a * mul_b;
    acc_d = (state_q == StMulK) ? AccW'(prod) + (AccW'(ff_q) <<< FracShift)
                                : acc_q - AccW'(prod);
  end

  // scale and clip
  always_comb begin
    shr = acc_q >>> FracShift;
    lim = AccW'(signed'({1'b0, cfg_i.torque_limit}));
    if (shr > lim) begin
      tau_d = TorqueW'(lim);
    end else if (shr < -lim) begin
      tau_d = TorqueW'(-lim);
    end else begin
      tau_d = TorqueW'(shr);
    end
  end

  // window bookkeeping
  always_comb begin
    if (cfg_i.average_window == '0) begin
      win = WinW'(1);
    end else if (cfg_i.average_window > WinW'(WindowMax)) begin
      win = WinW'(WindowMax);
    end else begin
      win = cfg_i.average_window;
    end
    drop    = cnt_q[joint_q] >= win;
    cnt_new = drop ? cnt_q[joint_q] : cnt_q[joint_q] + 1'b1;
    sum_new = sum_q[joint_q] - (drop ? SumW'(ring_rd_q) : SumW'(0)) + SumW'(tau_q);
    ring_ra = {joint_q, head_q[joint_q] - cnt_q[joint_q][PtrW-1:0]};
    ring_wa = {joint_q, head_q[joint_q]};
  end

  assign div_req_o.start    = (state_q == StUpdate);
  assign div_req_o.dividend = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);
  assign div_req_o.divisor  = cnt_new;

  // slew limit
  always_comb begin
    q24  = div_rsp_i.quot[TorqueW-1:0];
    mag  = signed'({3'b000, q24});
    avg  = neg_q ? -mag : mag;
    prev = StepW'(last_q[joint_q]);
    stp  = StepW'(signed'({1'b0, cfg_i.max_step}));
    dlt  = avg - prev;
    res  = avg;
    if (has_q[joint_q] && (cfg_i.max_step != '0)) begin
      if (dlt > stp) begin
        res = prev + stp;
      end else if (dlt < -stp) begin
        res = prev - stp;
      end
    end
    if (res > StepW'(signed'({1'b0, {(TorqueW-1){1'b1}}}))) begin
      res_c = {1'b0, {(TorqueW-1){1'b1}}};
    end else if (res < StepW'(signed'({1'b1, {(TorqueW-1){1'b0}}}))) begin
      res_c = {1'b1, {(TorqueW-1){1'b0}}};
    end else begin
      res_c = TorqueW'(res);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && (in_i.joint < JointW'(Joints))) begin
          state_d = StMulK;
        end
      end
      StMulK:   state_d = StMulD;
      StMulD:   state_d = StClip;
      StClip:   state_d = StUpdate;
      StUpdate: state_d = StDiv;
      StDiv: begin
        if (div_rsp_i.done) begin
          state_d = StSlew;
        end
      end
      StSlew: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q <= in_i.joint;
      err_q   <= ErrW'(in_i.desired_position) - ErrW'(in_i.position);
      vel_q   <= in_i.velocity;
      ff_q    <= in_i.feedforward_torque;
    end
    if ((state_q == StMulK) || (state_q == StMulD)) begin
      acc_q <= acc_d;
    end
    if (state_q == StClip) begin
      tau_q <= tau_d;
    end
    if (state_q == StUpdate) begin
      neg_q <= sum_new[SumW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= tau_q;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Joints; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        sum_q[i]  <= '0;
        last_q[i] <= '0;
      end
      has_q <= '0;
    end else begin
      if (state_q == StUpdate) begin
        cnt_q[joint_q]  <= cnt_new;
        head_q[joint_q] <= head_q[joint_q] + 1'b1;
        sum_q[joint_q]  <= sum_new;
      end
      if (load_out) begin
        last_q[joint_q] <= res_c;
        has_q[joint_q]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_joint_q  <= joint_q;
      out_torque_q <= res_c;
    end
  end

endmodule

// File: rtl/core/joint_impedance_torque_filter_unit.sv
// Top level: joint impedance torque filter with moving average and slew limit.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    joint, position, velocity, desired_position,
//                                 feedforward_torque
//   out_o     out  valid/ready    out_joint, torque_command
//   apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// A new word is taken only once the previous one is in the output register; the
// 30-step serial divider for the moving average takes most of that time.
// A word for a joint index of 7 is dropped in its accept cycle.
// Reset clears per-joint sums, counts, heads and last outputs; the ring needs none.
// A finished word waits in the output register; the sequencer holds only when
// the next word is done before the previous one is taken.
module joint_impedance_torque_filter_unit import jitf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  jitf_in_if.sink             in_i,
  jitf_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  jitf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jitf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  jitf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

  a_drop_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.joint >= JointW'(Joints)) |=> in_i.ready)
    else $error("dropped word stalled the input");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.joint < JointW'(Joints)) |=> !in_i.ready)
    else $error("input ready while a word is in work");

  a_out_joint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.out_joint < JointW'(Joints)))
    else $error("result for a joint out of range");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

endmodule

// File: tb/joint_impedance_torque_filter_unit_test.sv
`timescale 1ns / 100ps
// Testbench for the joint impedance torque filter: shadow predictor, stall driver, word checker.
module joint_impedance_torque_filter_unit_test;
  import jitf_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned DrainCycles  = 60;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseSamples = 112;
  localparam longint      TorqueMax    = 8388607;
  localparam longint      TorqueMin    = -8388608;
  localparam int          PosMax       = 131071;
  localparam int          PosMin       = -131072;
  localparam int          FfMax        = 8388607;
  localparam int          FfMin        = -8388608;

  typedef struct packed {
    logic [JointW-1:0]         joint;
    logic signed [PosW-1:0]    position;
    logic signed [PosW-1:0]    velocity;
    logic signed [PosW-1:0]    desired_position;
    logic signed [TorqueW-1:0] feedforward_torque;
  } sample_t;

  typedef struct packed {
    logic [JointW-1:0]         joint;
    logic signed [TorqueW-1:0] torque;
  } command_t;

  typedef struct {
    sample_t     s;
    int unsigned gap;
  } pending_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  jitf_in_if  sample_if ();
  jitf_out_if torque_if ();

  joint_impedance_torque_filter_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sample_if),
    .out_o   (torque_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        shadow_cfg;
  longint      torque_hist [Joints][WindowMax];
  longint      hist_sum    [Joints];
  int unsigned hist_count  [Joints];
  int unsigned hist_head   [Joints];
  longint      last_cmd    [Joints];
  bit          cmd_seen    [Joints];

  pending_t    sample_q[$];
  command_t    cmd_q[$];
  int unsigned idle_pct;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  bit          sample_taken;

  function automatic bit predict_torque(input sample_t s, output command_t cmd);
    longint k, d, err, vel, ff, acc, tau, lim, avg, res, prev, stp;
    int unsigned win, cnt, head, oldest;
    int j;
    j = int'(s.joint);
    if (j >= Joints) return 0;
    k   = longint'(shadow_cfg.stiffness);
    d   = longint'(shadow_cfg.damping);
    err = longint'(s.desired_position) - longint'(s.position);
    vel = longint'(s.velocity);
    ff  = longint'(s.feedforward_torque);
    acc = k * err - d * vel + ff * 16384;
    tau = acc >>> FracShift;
    if (tau > TorqueMax) tau = TorqueMax;
    if (tau < TorqueMin) tau = TorqueMin;
    lim = longint'(shadow_cfg.torque_limit);
    if (tau > lim) tau = lim;
    if (tau < -lim) tau = -lim;

    win = 32'(shadow_cfg.average_window);
    if (win < 1) win = 1;
    if (win > WindowMax) win = WindowMax;
    cnt  = hist_count[j];
    head = hist_head[j];
    if (cnt + 1 > win && cnt > 0) begin
      oldest = (head + WindowMax - cnt) % WindowMax;
      hist_sum[j] -= torque_hist[j][oldest];
      cnt--;
    end
    torque_hist[j][head] = tau;
    hist_sum[j] += tau;
    cnt++;
    hist_count[j] = cnt;
    hist_head[j]  = (head + 1) % WindowMax;
    avg = hist_sum[j] / longint'(cnt);

    res = avg;
    if (cmd_seen[j] && shadow_cfg.max_step != 0) begin
      prev = last_cmd[j];
      stp  = longint'(shadow_cfg.max_step);
      if (avg - prev > stp) res = prev + stp;
      else if (avg - prev < -stp) res = prev - stp;
    end
    if (res > TorqueMax) res = TorqueMax;
    if (res < TorqueMin) res = TorqueMin;
    last_cmd[j] = res;
    cmd_seen[j] = 1'b1;
    cmd.joint  = s.joint;
    cmd.torque = res[TorqueW-1:0];
    return 1;
  endfunction

  function automatic logic [31:0] pick_reg(input int unsigned width, input int unsigned typical);
    case ($urandom_range(5))
      0: return 0;
      1: return (32'd1 << width) - 1;
      2: return $urandom & ((32'd1 << width) - 1);
      default: return $urandom_range(typical * 2);
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegStiffness:     shadow_cfg.stiffness      = value[GainW-1:0];
      RegDamping:       shadow_cfg.damping        = value[GainW-1:0];
      RegTorqueLimit:   shadow_cfg.torque_limit   = value[LimW-1:0];
      RegAverageWindow: shadow_cfg.average_window = value[WinW-1:0];
      RegMaxStep:       shadow_cfg.max_step       = value[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [31:0] k, d, lim, win, stp);
    write_reg(RegStiffness, k);
    write_reg(RegDamping, d);
    write_reg(RegTorqueLimit, lim);
    write_reg(RegAverageWindow, win);
    write_reg(RegMaxStep, stp);
  endtask

  task automatic push_sample(input int j, p, v, dp, f, input int unsigned gap);
    pending_t e;
    e.s.joint              = JointW'(j);
    e.s.position           = PosW'(p);
    e.s.velocity           = PosW'(v);
    e.s.desired_position   = PosW'(dp);
    e.s.feedforward_torque = TorqueW'(f);
    e.gap                  = gap;
    sample_q.insert(sample_q.size(), e);
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || sample_if.valid || cmd_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    pending_t e;
    if (rst_ni && (!sample_if.valid || sample_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_if.valid <= 1'b0;
      end else if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        e = sample_q[0];
        sample_q.delete(0);
        gap_left = e.gap;
        sample_if.valid              <= 1'b1;
        sample_if.joint              <= e.s.joint;
        sample_if.position           <= e.s.position;
        sample_if.velocity           <= e.s.velocity;
        sample_if.desired_position   <= e.s.desired_position;
        sample_if.feedforward_torque <= e.s.feedforward_torque;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        torque_if.ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        if ($urandom_range(15) == 0) stall_left = $urandom_range(90, 20);
        torque_if.ready <= 1'b0;
      end else begin
        torque_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t  s;
    command_t want;
    bit       out_taken;
    sample_taken = sample_if.valid && sample_if.ready;
    out_taken    = torque_if.valid && torque_if.ready;
    if (rst_ni) begin
      if (out_taken) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual joint %0d torque %0d",
                   $realtime, torque_if.out_joint, torque_if.torque_command);
          mismatches++;
        end else begin
          want = cmd_q[0];
          cmd_q.delete(0);
          if (torque_if.out_joint !== want.joint) begin
            $display("%0t: out_joint expected %0d actual %0d",
                     $realtime, want.joint, torque_if.out_joint);
            mismatches++;
          end
          if (torque_if.torque_command !== want.torque) begin
            $display("%0t: torque_command expected %0d actual %0d",
                     $realtime, want.torque, torque_if.torque_command);
            mismatches++;
          end
        end
      end
      if (sample_taken) begin
        s.joint              = sample_if.joint;
        s.position           = sample_if.position;
        s.velocity           = sample_if.velocity;
        s.desired_position   = sample_if.desired_position;
        s.feedforward_torque = sample_if.feedforward_torque;
        if (predict_torque(s, want)) cmd_q.insert(cmd_q.size(), want);
      end
      if (sample_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("[joint_impedance_torque_filter_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned phase, n, gap;
    int          j, p, v, dp, f;
    logic [31:0] win;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_if.valid              = 1'b0;
    sample_if.joint              = '0;
    sample_if.position           = '0;
    sample_if.velocity           = '0;
    sample_if.desired_position   = '0;
    sample_if.feedforward_torque = '0;
    torque_if.ready = 1'b0;
    idle_pct     = 33;
    gap_left     = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    sample_taken = 1'b0;
    shadow_cfg   = '{stiffness: StiffnessRst, damping: DampingRst, torque_limit: LimitRst,
                     average_window: WindowRst, max_step: MaxStepRst};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(0, PosMin, 0, PosMax, 0, 0);
    push_sample(0, PosMax, PosMax, PosMin, FfMin, 0);
    push_sample(1, 100, -200, 300, 1000, 0);
    push_sample(2, -5000, 4000, 5000, -7000, 0);
    push_sample(3, 0, PosMin, 0, FfMax, 0);
    push_sample(4, 16384, 0, 0, 0, 0);
    push_sample(5, 0, 0, 0, FfMin, 0);
    push_sample(6, PosMax, PosMax, PosMax, FfMax, 0);
    push_sample(7, PosMin, PosMin, PosMax, FfMax, 0);
    push_sample(6, 1, 1, 1, 1, 0);
    settle();
    write_config(32'hFFFFFF, 32'hFFFFFF, 32'h7FFFFF, 1, 0);
    push_sample(0, PosMin, PosMin, PosMax, FfMax, 0);
    push_sample(0, PosMax, PosMax, PosMin, FfMin, 0);
    push_sample(1, 0, 0, 0, FfMax, 0);
    push_sample(1, 0, 0, 0, FfMin, 0);
    push_sample(2, 0, 1, 0, 0, 0);
    settle();
    write_config(0, 0, 0, 0, 32'h7FFFFF);
    push_sample(3, PosMin, PosMax, PosMax, FfMax, 0);
    push_sample(3, 0, 0, 0, -1, 0);
    settle();
    write_config(32'(StiffnessRst), 32'(DampingRst), 32'h7FFFFF, 127, 32'h7FFFFF);
    push_sample(4, -3000, 1200, 2500, 40000, 0);
    push_sample(4, 9000, -800, -4000, -25000, 0);
    push_sample(4, 0, 0, 0, 0, 0);
    settle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      idle_pct = (phase == 2) ? 0 : 33;
      if (phase == 0) win = 64;
      else if (phase == 1) win = 3;
      else win = pick_reg(WinW, 50);
      write_config(pick_reg(GainW, 512000), pick_reg(GainW, 23040),
                   pick_reg(LimW, 51200), win, pick_reg(LimW, 256));
      for (n = 0; n < PhaseSamples; n++) begin
        j = ($urandom_range(15) == 0) ? 7 : $urandom_range(6);
        p = $urandom;
        if ($urandom_range(3) == 0) begin
          v  = $urandom;
          dp = $urandom;
          f  = $urandom;
        end else begin
          p  = int'($urandom_range(40000)) - 20000;
          dp = p + int'($urandom_range(2048)) - 1024;
          v  = int'($urandom_range(4096)) - 2048;
          f  = int'($urandom_range(65536)) - 32768;
        end
        gap = (idle_pct != 0 && $urandom_range(7) == 0) ? $urandom_range(45) : 0;
        push_sample(j, p, v, dp, f, gap);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("[joint_impedance_torque_filter_unit] OK");
    end else begin
      $display("[joint_impedance_torque_filter_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: joint_impedance_torque_filter_unit.f
rtl/core/jitf_pkg.sv
rtl/core/jitf_in_if.sv
rtl/core/jitf_out_if.sv
rtl/core/jitf_regs.sv
rtl/core/jitf_div.sv
rtl/core/jitf_ctrl.sv
rtl/core/joint_impedance_torque_filter_unit.sv
tb/joint_impedance_torque_filter_unit_test.sv
